// ----- design/pol_pkg.sv -----
// ----------------------------------------------------------------------------
// pol_pkg: shared types and constants of the positional ordered list
// request codes, status codes, field widths and controller/datapath bundles
// ----------------------------------------------------------------------------
package pol_pkg;

    localparam int CAPACITY_DEFAULT = 16;

    localparam int REQ_W    = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND   = 3'd0,
        REQ_INSERT   = 3'd1,
        REQ_DELETE   = 3'd2,
        REQ_SHOW_FWD = 3'd3,
        REQ_SHOW_BWD = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_INVALID = 3'd2,
        ST_RANGE   = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        EDIT_APPEND = 2'd0,
        EDIT_INSERT = 2'd1,
        EDIT_DELETE = 2'd2
    } t_edit;

    // controller to datapath
    typedef struct packed {
        logic    edit_en;
        t_edit   edit;
        logic    load_single;
        t_status single_status;
        logic    show_start;
        logic    show_bwd;
        logic    show_step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_empty;
        logic is_full;
        logic pos_zero;
        logic pos_past;
        logic one_entry;
        logic step_last;
    } t_dp_stat;

endpackage

// ----- design/pol_if.sv -----
// ----------------------------------------------------------------------------
// pol_if: handshake channels of the positional ordered list
// request channel and response channel, valid/ready with payload
// ----------------------------------------------------------------------------
interface pol_req_if;
    logic                              valid;
    logic                              ready;
    logic [pol_pkg::REQ_W-1:0]         req_type;
    logic signed [pol_pkg::DATA_W-1:0] value;
    logic [pol_pkg::POS_W-1:0]         position;

    modport source (output valid, output req_type, output value, output position,
                    input ready);
    modport sink   (input valid, input req_type, input value, input position,
                    output ready);
endinterface

interface pol_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [pol_pkg::STATUS_W-1:0]      status;
    logic signed [pol_pkg::DATA_W-1:0] item;
    logic                              last;

    modport source (output valid, output status, output item, output last,
                    input ready);
    modport sink   (input valid, input status, input item, input last,
                    output ready);
endinterface

// ----- design/pol_ctrl.sv -----
// ----------------------------------------------------------------------------
// pol_ctrl: request controller
// decodes requests, picks the status and sequences show streaming
// ----------------------------------------------------------------------------
module pol_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [pol_pkg::REQ_W-1:0] i_req_type,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    input  pol_pkg::t_dp_stat         i_stat,
    output pol_pkg::t_cmd             o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SHOW = 2'b10
    } t_state;

    t_state        r_state, n_state;
    logic          r_out_valid, n_out_valid;
    logic          out_free;
    logic          accept;
    pol_pkg::t_cmd cmd;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        cmd               = '0;
        cmd.edit          = pol_pkg::EDIT_APPEND;
        cmd.single_status = pol_pkg::ST_OK;
        n_state           = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        pol_pkg::REQ_APPEND: begin
                            cmd.load_single = 1'b1;
                            if (i_stat.is_full) begin
                                cmd.single_status = pol_pkg::ST_FULL;
                            end else begin
                                cmd.edit_en = 1'b1;
                                cmd.edit    = pol_pkg::EDIT_APPEND;
                            end
                        end
                        pol_pkg::REQ_INSERT: begin
                            cmd.load_single = 1'b1;
                            if (i_stat.pos_zero) begin
                                cmd.single_status = pol_pkg::ST_INVALID;
                            end else if (i_stat.is_full) begin
                                cmd.single_status = pol_pkg::ST_FULL;
                            end else begin
                                cmd.edit_en = 1'b1;
                                cmd.edit    = pol_pkg::EDIT_INSERT;
                            end
                        end
                        pol_pkg::REQ_DELETE: begin
                            cmd.load_single = 1'b1;
                            if (i_stat.is_empty) begin
                                cmd.single_status = pol_pkg::ST_EMPTY;
                            end else if (i_stat.pos_zero) begin
                                cmd.single_status = pol_pkg::ST_INVALID;
                            end else if (i_stat.pos_past) begin
                                cmd.single_status = pol_pkg::ST_RANGE;
                            end else begin
                                cmd.edit_en = 1'b1;
                                cmd.edit    = pol_pkg::EDIT_DELETE;
                            end
                        end
                        pol_pkg::REQ_SHOW_FWD, pol_pkg::REQ_SHOW_BWD: begin
                            if (i_stat.is_empty) begin
                                cmd.load_single   = 1'b1;
                                cmd.single_status = pol_pkg::ST_EMPTY;
                            end else begin
                                cmd.show_start = 1'b1;
                                cmd.show_bwd   = (i_req_type == pol_pkg::REQ_SHOW_BWD);
                                if (!i_stat.one_entry) begin
                                    n_state = S_SHOW;
                                end
                            end
                        end
                        default: begin
                            cmd.load_single = 1'b1;
                        end
                    endcase
                end
            end
            S_SHOW: begin
                if (out_free) begin
                    cmd.show_step = 1'b1;
                    if (i_stat.step_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_single || cmd.show_start || cmd.show_step) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // while streaming, the output register always holds an entry
    a_show_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHOW) |-> r_out_valid)
        else $error("show state without a pending result");

    // a show of more than one entry keeps streaming
    a_show_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.show_start && !i_stat.one_entry) |=> (r_state == S_SHOW))
        else $error("multi-entry show did not enter streaming");

endmodule

// ----- design/pol_dp.sv -----
// ----------------------------------------------------------------------------
// pol_dp: list datapath
// shifting entry cells, entry count, show read pointer and output register
// ----------------------------------------------------------------------------
module pol_dp #(
    parameter int CAPACITY = pol_pkg::CAPACITY_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [pol_pkg::DATA_W-1:0] i_value,
    input  logic [pol_pkg::POS_W-1:0]         i_position,
    input  pol_pkg::t_cmd                     i_cmd,
    output pol_pkg::t_dp_stat                 o_stat,
    output logic [pol_pkg::STATUS_W-1:0]      o_status,
    output logic signed [pol_pkg::DATA_W-1:0] o_item,
    output logic                              o_last
);

    localparam int CntW = $clog2(CAPACITY + 1);
    localparam int IdxW = $clog2(CAPACITY);
    localparam int PosW = pol_pkg::POS_W;

    logic signed [pol_pkg::DATA_W-1:0] r_entry [CAPACITY];
    logic [CntW-1:0]                   r_count, n_count;
    logic [CntW-1:0]                   r_step;
    logic                              r_bwd;
    logic [pol_pkg::STATUS_W-1:0]      r_status;
    logic signed [pol_pkg::DATA_W-1:0] r_item;
    logic                              r_last;

    logic [PosW-1:0]                   cnt_p;
    logic [PosW-1:0]                   pos_m1;
    logic [PosW-1:0]                   slot;
    logic                              is_delete;
    logic [CntW-1:0]                   step_sel;
    logic                              bwd_sel;
    logic [CntW-1:0]                   src;
    logic [IdxW-1:0]                   rd_idx;
    logic signed [pol_pkg::DATA_W-1:0] rd_data;
    logic                              show_last;

    assign cnt_p  = PosW'(r_count);
    assign pos_m1 = i_position - PosW'(1);

    // target cell of an edit
    always_comb begin
        is_delete = 1'b0;
        case (i_cmd.edit)
            pol_pkg::EDIT_APPEND: slot = cnt_p;
            pol_pkg::EDIT_INSERT: slot = (pos_m1 > cnt_p) ? cnt_p : pos_m1;
            pol_pkg::EDIT_DELETE: begin
                slot      = pos_m1;
                is_delete = 1'b1;
            end
            default: slot = cnt_p;
        endcase
    end

    // each cell takes the new word, its left or its right neighbor
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [PosW-1:0] Here = PosW'(g);
        logic signed [pol_pkg::DATA_W-1:0] left_val;
        logic signed [pol_pkg::DATA_W-1:0] right_val;
        logic signed [pol_pkg::DATA_W-1:0] n_entry;

        if (g == 0) begin : g_first
            assign left_val = i_value;
        end else begin : g_mid
            assign left_val = r_entry[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign right_val = r_entry[g];
        end else begin : g_inner
            assign right_val = r_entry[g+1];
        end

        always_comb begin
            n_entry = r_entry[g];
            if (is_delete) begin
                if ((Here >= slot) && (Here + PosW'(1) < cnt_p)) begin
                    n_entry = right_val;
                end
            end else if (Here == slot) begin
                n_entry = i_value;
            end else if ((Here > slot) && (Here <= cnt_p)) begin
                n_entry = left_val;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.edit_en) begin
                r_entry[g] <= n_entry;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.edit_en) begin
            if (is_delete) begin
                n_count = r_count - CntW'(1);
            end else begin
                n_count = r_count + CntW'(1);
            end
        end
    end

    // show read pointer
    assign step_sel  = i_cmd.show_start ? '0 : r_step;
    assign bwd_sel   = i_cmd.show_start ? i_cmd.show_bwd : r_bwd;
    assign src       = bwd_sel ? (r_count - CntW'(1) - step_sel) : step_sel;
    assign rd_idx    = src[IdxW-1:0];
    assign rd_data   = r_entry[rd_idx];
    assign show_last = (step_sel == r_count - CntW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_step  <= '0;
            r_bwd   <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.show_start || i_cmd.show_step) begin
                r_step <= step_sel + CntW'(1);
            end
            if (i_cmd.show_start) begin
                r_bwd <= i_cmd.show_bwd;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_single) begin
            r_status <= i_cmd.single_status;
            r_item   <= '0;
            r_last   <= 1'b1;
        end else if (i_cmd.show_start || i_cmd.show_step) begin
            r_status <= pol_pkg::ST_OK;
            r_item   <= rd_data;
            r_last   <= show_last;
        end
    end

    // status flags come from registers and request fields only
    assign o_stat.is_empty  = (r_count == '0);
    assign o_stat.is_full   = (r_count == CntW'(CAPACITY));
    assign o_stat.pos_zero  = (i_position == '0);
    assign o_stat.pos_past  = (i_position > cnt_p);
    assign o_stat.one_entry = (r_count == CntW'(1));
    assign o_stat.step_last = (r_step == r_count - CntW'(1));

    assign o_status = r_status;
    assign o_item   = r_item;
    assign o_last   = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(CAPACITY))
        else $error("entry count above capacity");

    a_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.edit_en && !is_delete) |=> (r_count == $past(r_count) + CntW'(1)))
        else $error("append or insert did not grow the list");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.show_step |-> (r_step < r_count))
        else $error("show step beyond the stored entries");

endmodule

// ----- design/positional_ordered_list.sv -----
// ----------------------------------------------------------------------------
// positional_ordered_list: bounded ordered list of signed words
// append, positional insert and delete, forward and backward listing
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                          transaction
//  i_req     in   req_type, value, position        one request
//  o_rsp     out  status, item, last               one result
//
//  append, insert, delete and unused codes: one result each, one request per
//  cycle while results are taken; the shifting cells register each accepted edit
//  show: one result per stored entry, one per cycle while results are taken,
//  request side held off until the entry with last has been loaded into the
//  output register; reset clears the entry count, the controller state and the
//  output valid; a stalled output holds its result and holds off the request side
//
module positional_ordered_list #(
    parameter int CAPACITY = pol_pkg::CAPACITY_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pol_req_if.sink   i_req,
    pol_rsp_if.source o_rsp
);

    pol_pkg::t_cmd     cmd;
    pol_pkg::t_dp_stat stat;

    // controller: decode, status choice, show sequencing, output valid
    pol_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_req_type  (i_req.req_type),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath: entry cells, count, read pointer, result payload
    pol_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_value    (i_req.value),
        .i_position (i_req.position),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_status   (o_rsp.status),
        .o_item     (o_rsp.item),
        .o_last     (o_rsp.last)
    );

endmodule
